// ===== src/slt_pkg.sv =====
`default_nettype none

package slt_pkg;

  localparam int LEXEME_DEPTH_DEF = 32;
  localparam logic [15:0] START_LINE_RST = 16'd1;

  localparam logic [39:0] KW_PRINT = "print";
  localparam logic [15:0] KW_IF    = "if";
  localparam logic [31:0] KW_THEN  = "then";
  localparam logic [31:0] KW_TRUE  = "true";
  localparam logic [39:0] KW_FALSE = "false";

  typedef enum logic [1:0] {
    CMD_CHAR    = 2'd0,
    CMD_END     = 2'd1,
    CMD_RESTART = 2'd2
  } slt_code_t;

  typedef enum logic [3:0] {
    MD_BEGIN, MD_IDENT, MD_ICONST, MD_SCONST, MD_COM, MD_ASSIGN,
    MD_NEQ, MD_LT, MD_GT, MD_AND, MD_OR
  } slt_mode_t;

  typedef enum logic [4:0] {
    TK_IDENT, TK_PRINT, TK_IF, TK_THEN, TK_TRUE, TK_FALSE, TK_ICONST, TK_SCONST,
    TK_PLUS, TK_MINUS, TK_STAR, TK_SLASH, TK_ASSIGN, TK_EQ, TK_NEQ, TK_LT,
    TK_LEQ, TK_GT, TK_GEQ, TK_LOGICAND, TK_LOGICOR, TK_LPAREN, TK_RPAREN,
    TK_SC, TK_ERR, TK_DONE
  } slt_tok_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_CHK, ST_WR, ST_TEND
  } slt_state_t;

  typedef struct packed {
    logic load_char;
    logic scan;
    logic done;
    logic restart;
    logic emit_char;
    logic emit_end;
  } slt_cmd_t;

  typedef struct packed {
    logic fin;
    logic more;
    logic rescan;
    logic out_free;
  } slt_stat_t;

endpackage

`default_nettype wire

// ===== src/slt_ram.sv =====
`default_nettype none

module slt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== src/slt_ctrl.sv =====
`default_nettype none

module slt_ctrl
  import slt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  input  wire logic [1:0] in_tuser,
  output logic            in_tready,
  input  wire slt_stat_t  stat,
  output slt_cmd_t        cmd
);

  slt_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          unique case (in_tuser)
            CMD_CHAR: begin
              cmd.load_char = 1'b1;
              state_nxt     = ST_SCAN;
            end
            CMD_END: begin
              cmd.done  = 1'b1;
              state_nxt = ST_CHK;
            end
            CMD_RESTART: begin
              cmd.restart = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        cmd.scan  = 1'b1;
        state_nxt = stat.fin ? ST_CHK : ST_IDLE;
      end
      ST_CHK: begin
        state_nxt = stat.more ? ST_WR : ST_TEND;
      end
      ST_WR: begin
        if (stat.out_free) begin
          cmd.emit_char = 1'b1;
          state_nxt     = ST_CHK;
        end
      end
      ST_TEND: begin
        if (stat.out_free) begin
          cmd.emit_end = 1'b1;
          state_nxt    = stat.rescan ? ST_SCAN : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/slt_dp.sv =====
`default_nettype none

module slt_dp
  import slt_pkg::*;
#(
  parameter int LEXEME_DEPTH = LEXEME_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [7:0]  in_char,
  input  wire logic        cfg_valid,
  input  wire logic [15:0] cfg_data,
  input  wire slt_cmd_t    cmd,
  output slt_stat_t        stat,
  input  wire logic        out_tready,
  output logic             out_valid,
  output logic             out_is_end,
  output logic [7:0]       out_char,
  output logic [4:0]       out_type,
  output logic [15:0]      out_line,
  output logic             out_trunc,
  output logic             out_last
);

  localparam int AW = $clog2(LEXEME_DEPTH);
  localparam int LW = $clog2(LEXEME_DEPTH + 1);
  localparam logic [LW-1:0] DEPTH_L = LW'(LEXEME_DEPTH);

  slt_mode_t   mode_r, mode_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic        ovf_r, ovf_nxt;
  logic [15:0] line_r, line_nxt;
  logic [15:0] start_line_r;
  logic [7:0]  char_r;
  logic [7:0]  kw_r [5];
  logic [LW-1:0] idx_r;
  logic [LW-1:0] dlen_r;
  slt_tok_t    tok_type_r;
  logic [15:0] tok_line_r;
  logic        tok_trunc_r;
  logic        rescan_r;
  logic        more_r;
  logic        out_valid_r;
  logic        out_is_end_r;
  logic [7:0]  out_char_r;
  logic [4:0]  out_type_r;
  logic [15:0] out_line_r;
  logic        out_trunc_r;
  logic        out_last_r;

  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    rdata;
  logic          do_app;
  logic          fin;
  slt_tok_t      fin_type;
  logic          skip;
  logic          rescan;
  logic          is_alpha;
  logic          is_digit;
  logic          is_single;
  logic [15:0]   line_inc;
  logic [15:0]   line_dec;
  slt_tok_t      id_type;
  logic          out_free;

  slt_ram #(
    .WIDTH (8),
    .DEPTH (LEXEME_DEPTH)
  ) u_buf (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (char_r),
    .raddr (idx_r[AW-1:0]),
    .rdata (rdata)
  );

  assign is_alpha  = (char_r >= "a" && char_r <= "z") || (char_r >= "A" && char_r <= "Z");
  assign is_digit  = char_r >= "0" && char_r <= "9";
  assign is_single = char_r inside {"+", "-", "*", "/", "(", ")", ";", "."};
  assign line_inc  = line_r + 16'd1;
  assign line_dec  = (line_r == 16'd0) ? 16'd0 : line_r - 16'd1;
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    id_type = TK_IDENT;
    if (len_r == LW'(5) && {kw_r[0], kw_r[1], kw_r[2], kw_r[3], kw_r[4]} == KW_PRINT) begin
      id_type = TK_PRINT;
    end else if (len_r == LW'(2) && {kw_r[0], kw_r[1]} == KW_IF) begin
      id_type = TK_IF;
    end else if (len_r == LW'(4) && {kw_r[0], kw_r[1], kw_r[2], kw_r[3]} == KW_THEN) begin
      id_type = TK_THEN;
    end else if (len_r == LW'(4) && {kw_r[0], kw_r[1], kw_r[2], kw_r[3]} == KW_TRUE) begin
      id_type = TK_TRUE;
    end else if (len_r == LW'(5)
                 && {kw_r[0], kw_r[1], kw_r[2], kw_r[3], kw_r[4]} == KW_FALSE) begin
      id_type = TK_FALSE;
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    we       = 1'b0;
    waddr    = len_r[AW-1:0];
    len_nxt  = len_r;
    ovf_nxt  = ovf_r;
    line_nxt = line_r;
    do_app   = 1'b0;
    fin      = 1'b0;
    fin_type = TK_ERR;
    skip     = 1'b0;
    rescan   = 1'b0;
    unique case (mode_r)
      MD_BEGIN: begin
        if (char_r == 8'h0A) begin
          line_nxt = line_inc;
        end else if (char_r != " ") begin
          we      = 1'b1;
          waddr   = '0;
          len_nxt = LW'(1);
          ovf_nxt = 1'b0;
          if (is_alpha) begin
            mode_nxt = MD_IDENT;
          end else if (is_digit) begin
            mode_nxt = MD_ICONST;
          end else begin
            case (char_r)
              "\"": mode_nxt = MD_SCONST;
              "#":  mode_nxt = MD_COM;
              "=":  mode_nxt = MD_ASSIGN;
              "!":  mode_nxt = MD_NEQ;
              "<":  mode_nxt = MD_LT;
              ">":  mode_nxt = MD_GT;
              "&":  mode_nxt = MD_AND;
              "|":  mode_nxt = MD_OR;
              "+": begin fin = 1'b1; fin_type = TK_PLUS;   end
              "-": begin fin = 1'b1; fin_type = TK_MINUS;  end
              "*": begin fin = 1'b1; fin_type = TK_STAR;   end
              "/": begin fin = 1'b1; fin_type = TK_SLASH;  end
              "(": begin fin = 1'b1; fin_type = TK_LPAREN; end
              ")": begin fin = 1'b1; fin_type = TK_RPAREN; end
              ";": begin fin = 1'b1; fin_type = TK_SC;     end
              ".": begin
                fin      = 1'b1;
                fin_type = TK_ERR;
                line_nxt = line_dec;
              end
              default: begin
              end
            endcase
          end
        end
      end
      MD_IDENT: begin
        if (is_alpha || is_digit) begin
          do_app = 1'b1;
        end else begin
          fin      = 1'b1;
          fin_type = id_type;
          rescan   = 1'b1;
        end
      end
      MD_ICONST: begin
        if (is_alpha) begin
          do_app   = 1'b1;
          line_nxt = line_dec;
          fin      = 1'b1;
          fin_type = TK_ERR;
        end else if (!is_digit) begin
          fin      = 1'b1;
          fin_type = TK_ICONST;
          rescan   = 1'b1;
        end else begin
          do_app = 1'b1;
        end
      end
      MD_SCONST: begin
        if (char_r == "\"") begin
          fin      = 1'b1;
          fin_type = TK_SCONST;
          skip     = 1'b1;
        end else begin
          do_app = 1'b1;
          if (char_r == 8'h0A) begin
            fin      = 1'b1;
            fin_type = TK_ERR;
          end
        end
      end
      MD_COM: begin
        if (char_r == 8'h0A) begin
          line_nxt = line_inc;
          mode_nxt = MD_BEGIN;
        end
      end
      MD_ASSIGN, MD_LT, MD_GT: begin
        do_app = 1'b1;
        fin    = 1'b1;
        if (char_r == "=") begin
          fin_type = (mode_r == MD_ASSIGN) ? TK_EQ : (mode_r == MD_LT) ? TK_LEQ : TK_GEQ;
        end else begin
          fin_type = (mode_r == MD_ASSIGN) ? TK_ASSIGN : (mode_r == MD_LT) ? TK_LT : TK_GT;
          rescan   = 1'b1;
        end
      end
      MD_NEQ, MD_AND, MD_OR: begin
        fin      = 1'b1;
        fin_type = TK_ERR;
        if (char_r != 8'h0A) begin
          do_app = 1'b1;
          if ((mode_r == MD_NEQ && char_r == "=") || (mode_r == MD_AND && char_r == "&")
              || (mode_r == MD_OR && char_r == "|")) begin
            fin_type = (mode_r == MD_NEQ) ? TK_NEQ : (mode_r == MD_AND) ? TK_LOGICAND
                                                                        : TK_LOGICOR;
          end else begin
            rescan = 1'b1;
          end
        end
      end
      default: begin
        mode_nxt = MD_BEGIN;
      end
    endcase
    if (do_app) begin
      if (len_r < DEPTH_L) begin
        we      = 1'b1;
        waddr   = len_r[AW-1:0];
        len_nxt = len_r + LW'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
    if (fin) begin
      mode_nxt = MD_BEGIN;
    end
    if (!cmd.scan) begin
      we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MD_BEGIN;
      len_r        <= '0;
      ovf_r        <= 1'b0;
      line_r       <= '0;
      start_line_r <= START_LINE_RST;
      rescan_r     <= 1'b0;
      more_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        start_line_r <= cfg_data;
      end
      if (cmd.restart) begin
        line_r <= start_line_r;
      end
      if (cmd.scan) begin
        mode_r   <= mode_nxt;
        line_r   <= line_nxt;
        rescan_r <= rescan;
        more_r   <= rescan && is_single;
        if (fin) begin
          len_r <= '0;
          ovf_r <= 1'b0;
        end else begin
          len_r <= len_nxt;
          ovf_r <= ovf_nxt;
        end
      end
      if (cmd.done) begin
        mode_r   <= MD_BEGIN;
        line_r   <= line_dec;
        len_r    <= '0;
        ovf_r    <= 1'b0;
        rescan_r <= 1'b0;
        more_r   <= 1'b0;
      end
      if (cmd.emit_char || cmd.emit_end) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_char) begin
      char_r <= in_char;
    end
    if (we && waddr < AW'(5)) begin
      kw_r[waddr[2:0]] <= char_r;
    end
    if (cmd.scan && fin) begin
      dlen_r      <= len_nxt;
      idx_r       <= {{(LW-1){1'b0}}, skip};
      tok_type_r  <= fin_type;
      tok_line_r  <= line_nxt;
      tok_trunc_r <= ovf_nxt;
    end
    if (cmd.done) begin
      dlen_r      <= len_r;
      idx_r       <= '0;
      tok_type_r  <= TK_DONE;
      tok_line_r  <= line_dec;
      tok_trunc_r <= ovf_r;
    end
    if (cmd.emit_char) begin
      idx_r        <= idx_r + LW'(1);
      out_is_end_r <= 1'b0;
      out_char_r   <= rdata;
      out_type_r   <= '0;
      out_line_r   <= '0;
      out_trunc_r  <= 1'b0;
      out_last_r   <= 1'b0;
    end
    if (cmd.emit_end) begin
      out_is_end_r <= 1'b1;
      out_char_r   <= '0;
      out_type_r   <= tok_type_r;
      out_line_r   <= tok_line_r;
      out_trunc_r  <= tok_trunc_r;
      out_last_r   <= !more_r;
    end
  end

  assign stat.fin      = fin;
  assign stat.more     = idx_r < dlen_r;
  assign stat.rescan   = rescan_r;
  assign stat.out_free = out_free;

  assign out_valid  = out_valid_r;
  assign out_is_end = out_is_end_r;
  assign out_char   = out_char_r;
  assign out_type   = out_type_r;
  assign out_line   = out_line_r;
  assign out_trunc  = out_trunc_r;
  assign out_last   = out_last_r;

endmodule

`default_nettype wire

// ===== src/small_language_tokenizer_top.sv =====
// Tokenizer for a small language, fed one character per input item.
// Input channel: in_tuser carries the command (character, end of input,
// restart of the line counter) and in_tdata the character byte.
// Result channel: each token comes out as one item per lexeme character
// (out_tuser low), then one token-end item (out_tuser high) with the token
// type, the line number and the truncation flag. out_tlast marks the final
// result caused by an input item. The cfg channel loads the start line used
// by the restart command; it is always ready.
// A character item is accepted and then scanned; a restart only reloads the
// line counter. Each finished token is then drained from the lexeme buffer,
// which has a registered read port, one entry at a time into the output
// register, followed by its token-end item; a character that ends a token
// without belonging to it is scanned again. An end-of-input item drains the
// held characters the same way before its end item.
// A new item is accepted only after the results of the previous one have been
// handed to the output register, which holds the last result while the
// receiver stalls; a stall freezes the drain in place.
// Reset clears the scanner to its begin state, the line counter to 0 and the
// start line to 1; no clearing pass is needed.
`default_nettype none

module small_language_tokenizer_top
  import slt_pkg::*;
#(
  parameter int LEXEME_DEPTH = LEXEME_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // char_code
  input  wire logic [1:0]  in_tuser,   // command
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // lexeme_char, token_type, line_number, lexeme_truncated
  output logic             out_tuser,  // is_token_end
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  slt_cmd_t    cmd;
  slt_stat_t   stat;
  logic [7:0]  o_char;
  logic [4:0]  o_type;
  logic [15:0] o_line;
  logic        o_trunc;

  slt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  slt_dp #(
    .LEXEME_DEPTH (LEXEME_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_char    (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .stat       (stat),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_is_end (out_tuser),
    .out_char   (o_char),
    .out_type   (o_type),
    .out_line   (o_line),
    .out_trunc  (o_trunc),
    .out_last   (out_tlast)
  );

  assign out_tdata = {2'b00, o_trunc, o_line, o_type, o_char};
  assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

// ===== src/slt_checker.sv =====
`default_nettype none

module slt_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic        out_tuser,
  input wire logic        out_tlast
);

  // A lexeme character is always followed by its token end.
  a_char_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> !out_tlast)
    else $error("lexeme character item marked last");

  a_char_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[31:8] == 24'd0)
    else $error("lexeme character item carries token fields");

  a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[7:0] == 8'd0 && out_tdata[12:8] <= 5'd25)
    else $error("token end item malformed");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

endmodule

bind small_language_tokenizer_top slt_checker u_slt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire
